>>> rtl/tsc2p_pkg.sv
package tsc2p_pkg;

	localparam int SPAN_W  = 16;
	localparam int SIZE_W  = 10;
	localparam int CFG10_W = 10;
	localparam int PROD_W  = SPAN_W + SIZE_W;
	localparam int CNT_W   = $clog2(PROD_W);
	localparam int OUT_W   = 88;

	localparam logic [SPAN_W-1:0] LIMIT_OVER = 16'd2000;

	localparam logic [1:0] MODE_SAMPLE = 2'd0;
	localparam logic [1:0] MODE_CAL    = 2'd1;
	localparam logic [1:0] MODE_LOAD   = 2'd2;

	localparam logic [2:0] PH_RUN    = 3'd0;
	localparam logic [2:0] PH_WAIT_Z = 3'd1;
	localparam logic [2:0] PH_ZERO_A = 3'd2;
	localparam logic [2:0] PH_ZERO_B = 3'd3;
	localparam logic [2:0] PH_WAIT_F = 3'd4;
	localparam logic [2:0] PH_FAR_A  = 3'd5;
	localparam logic [2:0] PH_FAR_B  = 3'd6;

	localparam logic [2:0] REG_X_ZERO = 3'd0;
	localparam logic [2:0] REG_Y_ZERO = 3'd1;
	localparam logic [2:0] REG_X_SPAN = 3'd2;
	localparam logic [2:0] REG_Y_SPAN = 3'd3;
	localparam logic [2:0] REG_THRESH = 3'd4;
	localparam logic [2:0] REG_WIDTH  = 3'd5;
	localparam logic [2:0] REG_HEIGHT = 3'd6;

	localparam logic [CFG10_W-1:0] RST_X_ZERO = 10'd178;
	localparam logic [CFG10_W-1:0] RST_Y_ZERO = 10'd280;
	localparam logic [SPAN_W-1:0]  RST_X_SPAN = 16'd602;
	localparam logic [SPAN_W-1:0]  RST_Y_SPAN = 16'd348;
	localparam logic [CFG10_W-1:0] RST_THRESH = 10'd1010;
	localparam logic [SIZE_W-1:0]  RST_WIDTH  = 10'd240;
	localparam logic [SIZE_W-1:0]  RST_HEIGHT = 10'd128;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

>>> rtl/touchscreen_two_point_calibrate_unit.sv
// Two-point touchscreen calibration.
// Input stream (s_*): one touch reading per transfer, mode plus two raw
// samples per axis. Output stream (m_*): one result per reading with the
// scaled position, touch flag, calibration phase and active calibration.
// Config port: cfg_we/cfg_index/cfg_data writes the stored calibration,
// threshold and screen size; write only while the block is idle.
// Sequence: a reading that is not scaled in run phase passes from the
// input transfer through the update and final states to a valid result.
// A run-phase reading scales each axis in turn: a multiply step, a
// divider load step, 26 quotient bits of the shared restoring divider
// (one per cycle) and a result step; a zero-span axis skips the divider.
// s_tready is high only while the sequencer is idle, so one reading is
// in flight at a time. The result sits in an output register: the next
// reading is taken while it waits, and the sequencer holds in its final
// state until the previous result has been transferred.
// Reset (arst_n low) returns to run phase with the default calibration,
// config registers at their defaults and no result pending.
module touchscreen_two_point_calibrate_unit
	import tsc2p_pkg::*;
#(
	parameter int ADC_BITS = 10
)(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// mode[1:0], x_sample_a, x_sample_b, y_sample_a, y_sample_b, zero pad
	input  logic [((2 + 4 * ADC_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	// x_pos[9:0], y_pos[19:10], touched[20], cal_phase[23:21],
	// cal_x_zero[39:24], cal_y_zero[55:40], cal_x_span[71:56], cal_y_span[87:72]
	output logic [OUT_W-1:0]    m_tdata,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [SPAN_W-1:0]   cfg_data
);

	localparam int SUM_W = ADC_BITS + 1;
	localparam int CMP_W = (ADC_BITS > CFG10_W) ? ADC_BITS : CFG10_W;

	typedef enum logic [2:0] {ST_IDLE, ST_UPD, ST_MUL, ST_DIV, ST_FIN} state_t;

	state_t state_q;

	// config registers
	logic [CFG10_W-1:0] st_x_zero_q, st_y_zero_q, thresh_q;
	logic [SPAN_W-1:0]  st_x_span_q, st_y_span_q;
	logic [SIZE_W-1:0]  width_q, height_q;

	// calibration state
	logic [2:0]        phase_q;
	logic [SPAN_W-1:0] x_zero_q, y_zero_q, x_span_q, y_span_q;
	logic [SUM_W-1:0]  sum_x_q, sum_y_q;

	// item in flight
	logic [1:0]          mode_q;
	logic [ADC_BITS-1:0] avg_x_q, avg_y_q;
	logic                touched_q;
	logic                axis_q;
	logic [SIZE_W-1:0]   x_res_q, y_res_q;
	logic [PROD_W-1:0]   prod_q;
	logic                div_start_q;

	logic             out_valid_q;
	logic [OUT_W-1:0] out_q;

	// input fields
	logic [1:0]          in_mode;
	logic [ADC_BITS-1:0] in_xa, in_xb, in_ya, in_yb;
	logic [SUM_W-1:0]    in_sx, in_sy;

	assign in_mode = s_tdata[1:0];
	assign in_xa   = s_tdata[2 + ADC_BITS - 1 -: ADC_BITS];
	assign in_xb   = s_tdata[2 + 2 * ADC_BITS - 1 -: ADC_BITS];
	assign in_ya   = s_tdata[2 + 3 * ADC_BITS - 1 -: ADC_BITS];
	assign in_yb   = s_tdata[2 + 4 * ADC_BITS - 1 -: ADC_BITS];
	assign in_sx   = {1'b0, in_xa} + {1'b0, in_xb};
	assign in_sy   = {1'b0, in_ya} + {1'b0, in_yb};

	logic             touch;
	logic [SUM_W-1:0] sum_x_new, sum_y_new;
	logic             run_scale;

	assign touch = !((CMP_W'(avg_x_q) > CMP_W'(thresh_q)) &&
	                 (CMP_W'(avg_y_q) > CMP_W'(thresh_q)));
	assign sum_x_new = sum_x_q + {1'b0, avg_x_q};
	assign sum_y_new = sum_y_q + {1'b0, avg_y_q};
	// sample in run phase (the unused phase code counts as run phase)
	assign run_scale = (mode_q == MODE_SAMPLE) &&
	                   ((phase_q == PH_RUN) || (phase_q > PH_FAR_B));

	// per-axis operand select for the shared scaler
	logic [ADC_BITS-1:0] avg_sel;
	logic [SPAN_W-1:0]   zero_sel, span_sel, diff_sel;
	logic [SIZE_W-1:0]   size_sel;

	assign avg_sel  = axis_q ? avg_y_q : avg_x_q;
	assign zero_sel = axis_q ? y_zero_q : x_zero_q;
	assign span_sel = axis_q ? y_span_q : x_span_q;
	assign size_sel = axis_q ? height_q : width_q;
	assign diff_sel = SPAN_W'(avg_sel) - zero_sel;

	div_stat_t         div_stat;
	logic [PROD_W-1:0] quotient;
	logic [SPAN_W-1:0] q16;
	logic [SIZE_W-1:0] clamped;

	tsc2p_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (prod_q),
		.divisor  (span_sel),
		.stat     (div_stat),
		.quotient (quotient)
	);

	assign q16 = quotient[SPAN_W-1:0];

	always_comb begin
		priority if (q16 > LIMIT_OVER)
			clamped = '0;
		else if (q16 > SPAN_W'(size_sel))
			clamped = size_sel;
		else
			clamped = q16[SIZE_W-1:0];
	end

	logic in_fire, out_load;

	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign out_load = (state_q == ST_FIN) && (!out_valid_q || m_tready);

	// config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_x_zero_q <= RST_X_ZERO;
			st_y_zero_q <= RST_Y_ZERO;
			st_x_span_q <= RST_X_SPAN;
			st_y_span_q <= RST_Y_SPAN;
			thresh_q    <= RST_THRESH;
			width_q     <= RST_WIDTH;
			height_q    <= RST_HEIGHT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_X_ZERO: st_x_zero_q <= cfg_data[CFG10_W-1:0];
				REG_Y_ZERO: st_y_zero_q <= cfg_data[CFG10_W-1:0];
				REG_X_SPAN: st_x_span_q <= cfg_data;
				REG_Y_SPAN: st_y_span_q <= cfg_data;
				REG_THRESH: thresh_q    <= cfg_data[CFG10_W-1:0];
				REG_WIDTH:  width_q     <= cfg_data[SIZE_W-1:0];
				REG_HEIGHT: height_q    <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer, calibration state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_RUN;
			x_zero_q    <= SPAN_W'(RST_X_ZERO);
			y_zero_q    <= SPAN_W'(RST_Y_ZERO);
			x_span_q    <= RST_X_SPAN;
			y_span_q    <= RST_Y_SPAN;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			axis_q      <= 1'b0;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			div_start_q <= (state_q == ST_MUL) && (span_sel != '0);
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_fire)
						state_q <= ST_UPD;
				end
				ST_UPD: begin
					state_q <= run_scale ? ST_MUL : ST_FIN;
					axis_q  <= 1'b0;
					unique case (mode_q)
						MODE_CAL: phase_q <= PH_WAIT_Z;
						MODE_LOAD: begin
							x_zero_q <= SPAN_W'(st_x_zero_q);
							y_zero_q <= SPAN_W'(st_y_zero_q);
							x_span_q <= st_x_span_q;
							y_span_q <= st_y_span_q;
							phase_q  <= PH_RUN;
						end
						MODE_SAMPLE: begin
							unique case (phase_q)
								PH_WAIT_Z, PH_WAIT_F: begin
									if (touch)
										phase_q <= phase_q + 3'd1;
								end
								PH_ZERO_A, PH_FAR_A: begin
									sum_x_q <= {1'b0, avg_x_q};
									sum_y_q <= {1'b0, avg_y_q};
									phase_q <= phase_q + 3'd1;
								end
								PH_ZERO_B: begin
									sum_x_q  <= sum_x_new;
									sum_y_q  <= sum_y_new;
									x_zero_q <= SPAN_W'(sum_x_new[SUM_W-1:1]);
									y_zero_q <= SPAN_W'(sum_y_new[SUM_W-1:1]);
									phase_q  <= PH_WAIT_F;
								end
								PH_FAR_B: begin
									sum_x_q  <= sum_x_new;
									sum_y_q  <= sum_y_new;
									x_span_q <= SPAN_W'(sum_x_new[SUM_W-1:1]) - x_zero_q;
									y_span_q <= SPAN_W'(sum_y_new[SUM_W-1:1]) - y_zero_q;
									phase_q  <= PH_RUN;
								end
								default: begin
									// run phase, also the unused code
									phase_q <= PH_RUN;
								end
							endcase
						end
						default: ;
					endcase
				end
				ST_MUL: begin
					if (span_sel == '0) begin
						// zero span saturates, no division
						axis_q  <= 1'b1;
						state_q <= axis_q ? ST_FIN : ST_MUL;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						axis_q  <= 1'b1;
						state_q <= axis_q ? ST_FIN : ST_MUL;
					end
				end
				ST_FIN: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_q  <= in_mode;
			avg_x_q <= in_sx[SUM_W-1:1];
			avg_y_q <= in_sy[SUM_W-1:1];
		end
		if (state_q == ST_UPD) begin
			touched_q <= (mode_q == MODE_SAMPLE) && touch;
			x_res_q   <= '0;
			y_res_q   <= '0;
		end
		if (state_q == ST_MUL) begin
			prod_q <= PROD_W'(diff_sel) * PROD_W'(size_sel);
			if (span_sel == '0) begin
				if (axis_q)
					y_res_q <= size_sel;
				else
					x_res_q <= size_sel;
			end
		end
		if ((state_q == ST_DIV) && div_stat.done) begin
			if (axis_q)
				y_res_q <= clamped;
			else
				x_res_q <= clamped;
		end
		if (out_load)
			out_q <= {y_span_q, x_span_q, y_zero_q, x_zero_q, phase_q, touched_q,
			          y_res_q, x_res_q};
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	a_ready_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !div_stat.busy)
		else $error("input ready while divider busy");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !s_tready)
		else $error("second reading taken while one is in flight");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_DIV))
		else $error("divider result outside divide state");

	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != 3'd7)
		else $error("illegal calibration phase");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |=> out_valid_q && $stable(out_q))
		else $error("pending result overwritten");

endmodule

>>> rtl/tsc2p_div.sv
module tsc2p_div
	import tsc2p_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] dividend,
	input  logic [SPAN_W-1:0] divisor,
	output div_stat_t         stat,
	output logic [PROD_W-1:0] quotient
);

	logic [SPAN_W-1:0] rem_q;
	logic [PROD_W-1:0] quo_q;
	logic [SPAN_W-1:0] dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [SPAN_W:0] trial;
	logic [SPAN_W:0] diff;
	logic            fits;

	// restoring division, one quotient bit per cycle, MSB first
	assign trial = {rem_q, quo_q[PROD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == CNT_W'(PROD_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[SPAN_W-1:0] : trial[SPAN_W-1:0];
			quo_q <= {quo_q[PROD_W-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule
